// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BCI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BCI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bci_pkg.sv =====
`timescale 1ns / 1ps

package bci_pkg;

  localparam int BCI_MAX_POINTS = 16;

  localparam int AMOUNT_W = 16;
  localparam int WORD_W   = 16;
  localparam int VALUE_W  = 14;
  localparam int QUERY_W  = 25;
  localparam int RESULT_W = 22;
  localparam int RATIO_W  = 12;
  localparam int WGT_W    = 13;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] FLAG_EASE = 2'b01;
  localparam logic [WGT_W-1:0] WGT_ONE = 13'd4096;
  localparam logic [RESULT_W-1:0] RESULT_MAX = 22'd4194048;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [AMOUNT_W-1:0] amount;
  } bci_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_WALK,
    ST_SEG,
    ST_DIV,
    ST_WGT,
    ST_EASE,
    ST_MUL,
    ST_FIN,
    ST_PUSH
  } bci_state_t;

  typedef logic [WGT_W-1:0] sine_rom_t [256];

  // quarter-wave sine in q1.12, fixed q30 taylor series, evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < 256; k++) begin
      x  = (64'd1686629713 * 64'(k)) >> 8;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      rom[k] = WGT_W'((s + 64'd131072) >> 18);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/bci_ram.sv =====
`timescale 1ns / 1ps

module bci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/breakpoint_curve_interpolator.sv =====
`timescale 1ns / 1ps
// write request: accepted with no result; write requests can follow back to back
// evaluate request: walks the breakpoint ram to its segment, runs the 12-step divider,
// then weights the segment (plus the ease step with the sine ease); early exits for an
// empty table, a clamped query or a flat segment skip the rest; in_tready returns with
// the result, so a new evaluate is taken only once the last is pushed, after any out_tready stall
// rst_n (synchronous, active low) clears point_count and handshake state, not the ram
`include "assert_macros.svh"

module breakpoint_curve_interpolator
  import bci_pkg::*;
#(
  parameter int MAX_POINTS = BCI_MAX_POINTS
) (
  input  logic                clk,
  input  logic                rst_n,
  // config: point_count
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  // in_tdata: point_index[3:0], point_amount[19:4], point_word[35:20],
  //           query_amount[60:36], zero fill[63:61]
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  // in_tuser: cmd
  input  logic                in_tuser,
  // out_tdata: curve_value[21:0], zero fill[23:22]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata
);

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SLOT_W = (CNT_W > 4) ? CNT_W : 4;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // input fields
  logic [3:0]          in_point_index;
  logic [AMOUNT_W-1:0] in_point_amount;
  logic [WORD_W-1:0]   in_point_word;
  logic [QUERY_W-1:0]  in_query_amount;

  assign in_point_index  = in_tdata[3:0];
  assign in_point_amount = in_tdata[19:4];
  assign in_point_word   = in_tdata[35:20];
  assign in_query_amount = in_tdata[60:36];

  bci_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]         point_count_r;
  logic signed [QUERY_W-1:0]  q_r, q_nxt;
  logic [IDX_W-1:0]           last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  bci_entry_t                 prev_r, prev_nxt;
  bci_entry_t                 cur_r, cur_nxt;
  logic [AMOUNT_W-1:0]        den_r, den_nxt;
  logic [AMOUNT_W-1:0]        rem_r, rem_nxt;
  logic [RATIO_W-1:0]         dvd_r, dvd_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [WGT_W-1:0]           lo_r, lo_nxt;
  logic [WGT_W-1:0]           w_r, w_nxt;
  logic signed [28:0]         prod_r, prod_nxt;
  logic [RESULT_W-1:0]        res_r, res_nxt;
  logic [RESULT_W-1:0]        out_data_r;
  logic                       out_valid_r;

  logic                       in_fire;
  logic                       slot_free;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [31:0]                ram_rdata;
  bci_entry_t                 rd_entry;
  bci_entry_t                 wr_entry;

  // shared compare/subtract against a breakpoint position
  logic [AMOUNT_W-1:0]        amt_sel;
  logic signed [QUERY_W:0]    diff;
  logic                       diff_neg;
  logic                       diff_zero;

  // divider step
  logic [AMOUNT_W+1:0]        trial;

  // request decode
  logic [CMP_W-1:0]           n_ext;
  logic                       slot_ok;
  logic                       seg_ease;

  // sine table port
  logic [8:0]                 rom_idx;
  logic [WGT_W-1:0]           rom_q;
  logic [WGT_W+3:0]           ease_step;

  // final sum
  logic signed [29:0]         total;
  logic signed [29:0]         rnd;

  assign rd_entry = bci_entry_t'(ram_rdata);
  assign wr_entry = '{word: in_point_word, amount: in_point_amount};

  bci_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  assign amt_sel   = (state_r == ST_SEG) ? prev_r.amount : rd_entry.amount;
  assign diff      = {q_r[QUERY_W-1], q_r} - $signed({2'b00, amt_sel, 8'h00});
  assign diff_neg  = diff[QUERY_W];
  assign diff_zero = (diff == '0);

  assign trial = {1'b0, rem_r, dvd_r[RATIO_W-1]} - {2'b00, den_r};

  always_comb begin
    n_ext = CMP_W'(point_count_r);
    if (n_ext > CMP_W'(MAX_POINTS)) begin
      n_ext = CMP_W'(MAX_POINTS);
    end
  end

  assign slot_ok  = SLOT_W'(in_point_index) < SLOT_W'(MAX_POINTS);
  assign seg_ease = (cur_r.word[WORD_W-1:VALUE_W] == FLAG_EASE);

  assign rom_idx = (state_r == ST_EASE) ? ({1'b0, dvd_r[RATIO_W-1:4]} + 9'd1)
                                        : {1'b0, dvd_r[RATIO_W-1:4]};
  assign rom_q   = rom_idx[8] ? WGT_ONE : SINE_ROM[rom_idx[7:0]];
  assign ease_step = (rom_q - lo_r) * dvd_r[3:0];

  assign total = $signed({4'b0000, prev_r.word[VALUE_W-1:0], 12'h000})
               + 30'(prod_r);
  assign rnd   = total + 30'sd8;

  // handshake outputs and ram write port
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    in_fire    = in_tvalid && in_tready;
    slot_free  = !out_valid_r || out_tready;
    ram_we     = in_fire && !in_tuser && slot_ok;
    ram_waddr  = IDX_W'(in_point_index);
    out_tvalid = out_valid_r;
    out_tdata  = {2'b00, out_data_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tuser) begin
          state_nxt = (n_ext == '0) ? ST_PUSH : ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_nxt = (diff_neg || diff_zero) ? ST_PUSH : ST_LAST;
      end
      ST_LAST: begin
        state_nxt = diff_neg ? ST_WALK : ST_PUSH;
      end
      ST_WALK: begin
        if (diff_neg) begin
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        state_nxt = (cur_r.amount > prev_r.amount) ? ST_DIV : ST_PUSH;
      end
      ST_DIV: begin
        if (cnt_r == 4'(RATIO_W - 1)) begin
          state_nxt = ST_WGT;
        end
      end
      ST_WGT: begin
        state_nxt = seg_ease ? ST_EASE : ST_MUL;
      end
      ST_EASE: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    q_nxt        = q_r;
    last_idx_nxt = last_idx_r;
    idx_nxt      = idx_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    w_nxt        = w_r;
    prod_nxt     = prod_r;
    res_nxt      = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tuser) begin
          q_nxt        = $signed(in_query_amount);
          last_idx_nxt = IDX_W'(n_ext - 1'b1);
          idx_nxt      = '0;
          res_nxt      = '0;
        end
      end
      ST_FIRST: begin
        prev_nxt = rd_entry;
        res_nxt  = {rd_entry.word[VALUE_W-1:0], 8'h00};
        idx_nxt  = last_idx_r;
      end
      ST_LAST: begin
        res_nxt = {rd_entry.word[VALUE_W-1:0], 8'h00};
        idx_nxt = IDX_W'(1);
      end
      ST_WALK: begin
        if (diff_neg) begin
          cur_nxt = rd_entry;
        end else begin
          prev_nxt = rd_entry;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      ST_SEG: begin
        // descending or flat segment holds its first value
        res_nxt = {prev_r.word[VALUE_W-1:0], 8'h00};
        den_nxt = cur_r.amount - prev_r.amount;
        rem_nxt = diff[23:8];
        dvd_nxt = {diff[7:0], 4'h0};
        cnt_nxt = '0;
      end
      ST_DIV: begin
        // quotient bits shift in behind the dividend bits
        if (!trial[AMOUNT_W+1]) begin
          rem_nxt = trial[AMOUNT_W-1:0];
          dvd_nxt = {dvd_r[RATIO_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[AMOUNT_W-2:0], dvd_r[RATIO_W-1]};
          dvd_nxt = {dvd_r[RATIO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
      end
      ST_WGT: begin
        lo_nxt = rom_q;
        w_nxt  = {1'b0, dvd_r};
      end
      ST_EASE: begin
        w_nxt = lo_r + WGT_W'(ease_step >> 4);
      end
      ST_MUL: begin
        prod_nxt = ($signed({1'b0, cur_r.word[VALUE_W-1:0]})
                    - $signed({1'b0, prev_r.word[VALUE_W-1:0]}))
                   * $signed({1'b0, w_r});
      end
      ST_FIN: begin
        res_nxt = total[29] ? '0 : rnd[25:4];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
      if (state_r == ST_PUSH && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    last_idx_r <= last_idx_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    w_r        <= w_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    if (state_r == ST_PUSH && slot_free) begin
      out_data_r <= res_r;
    end
  end

  `BCI_ASSERT(a_walk_in_range, (state_r == ST_WALK) |-> (idx_r <= last_idx_r), "walk past last point")
  `BCI_ASSERT(a_weight_max, (state_r == ST_MUL) |-> (w_r <= WGT_ONE), "weight above one")
  `BCI_ASSERT(a_result_max, out_tvalid |-> (out_tdata[RESULT_W-1:0] <= RESULT_MAX), "result out of range")
  `BCI_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result shown after reset")

endmodule
